### hw/rtl/evst_pkg.sv
`timescale 1ns / 1ps

package evst_pkg;

    localparam int EVST_SLOTS = 64;

    localparam int IDX_W    = 6;
    localparam int SAMPLE_W = 32;
    localparam int AVG_W    = 40;
    localparam int ALPHA_W  = 17;
    localparam int CFG_W    = 17;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd6554;

    localparam logic [0:0] CFG_ALPHA  = 1'b0;
    localparam logic [0:0] CFG_PRIMED = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0]    event_index;
        logic [SAMPLE_W-1:0] cycle_count;
    } t_evst_req;

    typedef struct packed {
        logic [AVG_W-1:0]    average_q8;
        logic [SAMPLE_W-1:0] smallest_seen;
        logic [SAMPLE_W-1:0] largest_seen;
    } t_evst_stats;

    typedef struct packed {
        logic [IDX_W-1:0]    slot_index;
        logic [AVG_W-1:0]    average_q8;
        logic [SAMPLE_W-1:0] smallest_seen;
        logic [SAMPLE_W-1:0] largest_seen;
    } t_evst_rsp;

endpackage

### hw/rtl/event_stats_ema_min_max_table.sv
`timescale 1ns / 1ps

// channel   | handshake                 | payload
// ----------+---------------------------+------------------------------
// request   | start, busy (always low)  | i_request   (t_evst_req)
// result    | o_result_valid strobe     | o_result    (t_evst_rsp)
// config    | i_cfg_we, i_cfg_index     | i_cfg_data  (17 bits)
//
// one request per cycle; the result is registered in r_result behind the r_s1 request registers
// the slot is first read from the stats ram, then the update is computed and written back
// a request to the slot written in the same cycle is forwarded from the result register
// synchronous active-low reset clears the pipeline valids and resets the config registers
// results cannot be stalled; the ram contents are not cleared by reset

module event_stats_ema_min_max_table import evst_pkg::*; #(
    parameter int SLOTS = EVST_SLOTS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_evst_req        i_request,
    output logic             o_result_valid,
    output t_evst_rsp        o_result,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(SLOTS);
    localparam int STATS_W = $bits(t_evst_stats);

    function automatic logic [IDX_W-1:0] f_reduce(input logic [IDX_W-1:0] v);
        logic [16:0] r;
        r = {11'd0, v};
        for (int k = IDX_W - 1; k >= 0; k--) begin
            if (r >= (17'(SLOTS) << k)) begin
                r = r - (17'(SLOTS) << k);
            end
        end
        return r[IDX_W-1:0];
    endfunction

    logic [ALPHA_W-1:0]  r_alpha;
    logic                r_primed;
    logic                r_s1_valid;
    logic                r_s1_fwd;
    logic [IDX_W-1:0]    r_s1_slot;
    logic [SAMPLE_W-1:0] r_s1_sample;
    logic                r_out_valid;
    t_evst_rsp           r_result;

    logic                accept;
    logic [IDX_W-1:0]    slot_in;
    logic [STATS_W-1:0]  ram_q;
    t_evst_stats         old_stats;
    t_evst_stats         fwd_stats;
    t_evst_stats         new_stats;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign slot_in = f_reduce(i_request.event_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= ALPHA_RESET;
            r_primed <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ALPHA: begin
                    r_alpha <= i_cfg_data[ALPHA_W-1:0];
                end
                CFG_PRIMED: begin
                    r_primed <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s1_fwd    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= accept;
            r_s1_fwd    <= accept && r_s1_valid && (r_s1_slot == slot_in);
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_slot   <= slot_in;
            r_s1_sample <= i_request.cycle_count;
        end
        if (r_s1_valid) begin
            r_result.slot_index    <= r_s1_slot;
            r_result.average_q8    <= new_stats.average_q8;
            r_result.smallest_seen <= new_stats.smallest_seen;
            r_result.largest_seen  <= new_stats.largest_seen;
        end
    end

    evst_ram #(
        .WIDTH (STATS_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (AW'(r_s1_slot)),
        .i_wdata (new_stats),
        .i_raddr (AW'(slot_in)),
        .o_rdata (ram_q)
    );

    always_comb begin
        fwd_stats.average_q8    = r_result.average_q8;
        fwd_stats.smallest_seen = r_result.smallest_seen;
        fwd_stats.largest_seen  = r_result.largest_seen;
        old_stats = r_s1_fwd ? fwd_stats : t_evst_stats'(ram_q);
    end

    evst_upd u_upd (
        .i_primed (r_primed),
        .i_alpha  (r_alpha),
        .i_sample (r_s1_sample),
        .i_old    (old_stats),
        .o_new    (new_stats)
    );

    assign o_result_valid = r_out_valid;
    assign o_result       = r_result;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_result_valid)
        else $error("accepted request produced no result two cycles later");

    a_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(r_primed)
            || ((o_result.average_q8 == {o_result.smallest_seen, 8'd0})
                && (o_result.smallest_seen == o_result.largest_seen))))
        else $error("seeded slot statistics disagree");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (32'(o_result.slot_index) < 32'(SLOTS)))
        else $error("result slot out of range");

endmodule

### hw/rtl/evst_ram.sv
`timescale 1ns / 1ps

module evst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/evst_upd.sv
`timescale 1ns / 1ps

module evst_upd import evst_pkg::*; (
    input  logic                i_primed,
    input  logic [ALPHA_W-1:0]  i_alpha,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  t_evst_stats         i_old,
    output t_evst_stats         o_new
);

    localparam logic [ALPHA_W-1:0] ONE_Q16 = 17'd65536;

    logic [ALPHA_W-1:0]         alpha_sat;
    logic [AVG_W-1:0]           sample_q8;
    logic signed [AVG_W:0]      diff;
    logic signed [AVG_W+18:0]   prod;
    logic signed [AVG_W+18:0]   step;
    logic [AVG_W-1:0]           avg_next;

    // avg + a * (sample - avg) / 2^16, floored, equals the weighted form
    always_comb begin
        alpha_sat = (i_alpha > ONE_Q16) ? ONE_Q16 : i_alpha;
        sample_q8 = {i_sample, 8'd0};
        diff      = $signed({1'b0, sample_q8}) - $signed({1'b0, i_old.average_q8});
        prod      = diff * $signed({1'b0, alpha_sat});
        step      = prod >>> 16;
        avg_next  = i_old.average_q8 + step[AVG_W-1:0];
    end

    always_comb begin
        if (!i_primed) begin
            o_new.average_q8    = sample_q8;
            o_new.smallest_seen = i_sample;
            o_new.largest_seen  = i_sample;
        end else begin
            o_new.average_q8    = avg_next;
            o_new.smallest_seen = (i_sample < i_old.smallest_seen) ? i_sample
                                                                   : i_old.smallest_seen;
            o_new.largest_seen  = (i_sample > i_old.largest_seen) ? i_sample
                                                                  : i_old.largest_seen;
        end
    end

endmodule
